@@ sv/assert_macros.svh @@
// assertion macros used by the gelu checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/gta_pkg.sv @@
// constants and tanh table for the gelu tanh-approximation pipeline
`default_nettype none

package gta_pkg;

    // 0.7978846 and 0.044715 as unsigned q0.16
    localparam logic [15:0] GK_SCALE  = 16'd52290;
    localparam logic [11:0] GK_CUBE   = 12'd2930;
    // tanh 1.0 in unsigned q1.16
    localparam logic [16:0] T_ONE     = 17'd65536;
    // table segments over [0,4] in steps of 1/8
    localparam logic [5:0]  TAB_STEPS = 6'd32;

    // tanh at k/8, q1.16; entries past the table read as 1.0
    function automatic logic [16:0] tanh_entry(input logic [5:0] idx);
        logic [16:0] val;
        case (idx)
            6'd0:    val = 17'd0;
            6'd1:    val = 17'd8150;
            6'd2:    val = 17'd16051;
            6'd3:    val = 17'd23485;
            6'd4:    val = 17'd30285;
            6'd5:    val = 17'd36346;
            6'd6:    val = 17'd41625;
            6'd7:    val = 17'd46131;
            6'd8:    val = 17'd49912;
            6'd9:    val = 17'd53038;
            6'd10:   val = 17'd55593;
            6'd11:   val = 17'd57660;
            6'd12:   val = 17'd59320;
            6'd13:   val = 17'd60643;
            6'd14:   val = 17'd61694;
            6'd15:   val = 17'd62524;
            6'd16:   val = 17'd63178;
            6'd17:   val = 17'd63693;
            6'd18:   val = 17'd64096;
            6'd19:   val = 17'd64412;
            6'd20:   val = 17'd64659;
            6'd21:   val = 17'd64852;
            6'd22:   val = 17'd65002;
            6'd23:   val = 17'd65120;
            6'd24:   val = 17'd65212;
            6'd25:   val = 17'd65283;
            6'd26:   val = 17'd65339;
            6'd27:   val = 17'd65383;
            6'd28:   val = 17'd65417;
            6'd29:   val = 17'd65443;
            6'd30:   val = 17'd65464;
            6'd31:   val = 17'd65480;
            default: val = T_ONE;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

@@ sv/gta_cube.sv @@
// front stages: magnitude, square, cube and inner polynomial argument
`default_nettype none

module gta_cube #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 10
) (
    input  wire logic                  clk,
    input  wire logic [3:0]            en,
    input  wire logic [DATA_WIDTH-1:0] x_value,
    output logic [DATA_WIDTH-1:0]      a_out,
    output logic                       neg_out,
    output logic                       sat_out,
    output logic [FRAC_BITS+2:0]       v_out
);

    localparam int AW  = FRAC_BITS + 2;
    localparam int SQW = FRAC_BITS + 5;
    localparam int CBW = FRAC_BITS + 7;
    localparam int VW  = FRAC_BITS + 3;
    localparam int TPW = CBW + 12;
    localparam int CW  = (DATA_WIDTH > FRAC_BITS + 3) ? DATA_WIDTH : FRAC_BITS + 3;

    localparam logic [2*AW:0]   SQ_HALF = (2*AW+1)'(1) << (FRAC_BITS - 1);
    localparam logic [SQW+AW:0] CB_HALF = (SQW+AW+1)'(1) << (FRAC_BITS - 1);
    localparam logic [TPW:0]    TM_HALF = (TPW+1)'(1) << 15;
    localparam logic [CW-1:0]   SAT_LIM = CW'(4) << FRAC_BITS;

    logic                  neg;
    logic [DATA_WIDTH-1:0] a;
    logic                  sat;

    logic [DATA_WIDTH-1:0] s0_a_reg;
    logic                  s0_neg_reg;
    logic                  s0_sat_reg;
    logic [AW-1:0]         s0_am_reg;

    logic [2*AW-1:0]       sq_prod;
    logic [2*AW:0]         sq_rnd;
    logic [DATA_WIDTH-1:0] s1_a_reg;
    logic                  s1_neg_reg;
    logic                  s1_sat_reg;
    logic [AW-1:0]         s1_am_reg;
    logic [SQW-1:0]        s1_sq_reg;

    logic [SQW+AW-1:0]     cb_prod;
    logic [SQW+AW:0]       cb_rnd;
    logic [DATA_WIDTH-1:0] s2_a_reg;
    logic                  s2_neg_reg;
    logic                  s2_sat_reg;
    logic [AW-1:0]         s2_am_reg;
    logic [CBW-1:0]        s2_cube_reg;

    logic [TPW-1:0]        tm_prod;
    logic [TPW:0]          tm_rnd;
    logic [VW-1:0]         v_next;
    logic [DATA_WIDTH-1:0] s3_a_reg;
    logic                  s3_neg_reg;
    logic                  s3_sat_reg;
    logic [VW-1:0]         s3_v_reg;

    // magnitude; the most negative sample maps to 2^(DATA_WIDTH-1)
    assign neg = x_value[DATA_WIDTH-1];
    assign a   = neg ? (~x_value + 1'b1) : x_value;
    assign sat = CW'(a) >= SAT_LIM;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_a_reg   <= a;
            s0_neg_reg <= neg;
            s0_sat_reg <= sat;
            s0_am_reg  <= AW'(a);
        end
    end

    assign sq_prod = s0_am_reg * s0_am_reg;
    assign sq_rnd  = {1'b0, sq_prod} + SQ_HALF;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_a_reg   <= s0_a_reg;
            s1_neg_reg <= s0_neg_reg;
            s1_sat_reg <= s0_sat_reg;
            s1_am_reg  <= s0_am_reg;
            s1_sq_reg  <= sq_rnd[FRAC_BITS +: SQW];
        end
    end

    assign cb_prod = s1_sq_reg * s1_am_reg;
    assign cb_rnd  = {1'b0, cb_prod} + CB_HALF;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_a_reg    <= s1_a_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_sat_reg  <= s1_sat_reg;
            s2_am_reg   <= s1_am_reg;
            s2_cube_reg <= cb_rnd[FRAC_BITS +: CBW];
        end
    end

    // v = a + 0.044715 * a^3
    assign tm_prod = TPW'(gta_pkg::GK_CUBE) * TPW'(s2_cube_reg);
    assign tm_rnd  = {1'b0, tm_prod} + TM_HALF;
    assign v_next  = VW'(s2_am_reg) + VW'(tm_rnd[16 +: AW]);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_a_reg   <= s2_a_reg;
            s3_neg_reg <= s2_neg_reg;
            s3_sat_reg <= s2_sat_reg;
            s3_v_reg   <= v_next;
        end
    end

    assign a_out   = s3_a_reg;
    assign neg_out = s3_neg_reg;
    assign sat_out = s3_sat_reg;
    assign v_out   = s3_v_reg;

endmodule

`default_nettype wire

@@ sv/gta_tanh.sv @@
// middle stages: scale the argument, table lookup and linear interpolation of tanh
`default_nettype none

module gta_tanh #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 10
) (
    input  wire logic                  clk,
    input  wire logic [2:0]            en,
    input  wire logic [DATA_WIDTH-1:0] a_in,
    input  wire logic                  neg_in,
    input  wire logic                  sat_in,
    input  wire logic [FRAC_BITS+2:0]  v_in,
    output logic [DATA_WIDTH-1:0]      a_out,
    output logic                       neg_out,
    output logic [16:0]                t_out
);

    localparam int VW  = FRAC_BITS + 3;
    localparam int WPW = VW + 16;
    localparam int WW  = VW + 19;
    localparam int PW  = 22;
    localparam int SHL = (FRAC_BITS <= 19) ? 19 - FRAC_BITS : 0;
    localparam int SHR = (FRAC_BITS > 19) ? FRAC_BITS - 19 : 0;

    localparam logic [WPW:0] W_HALF  = (WPW+1)'(1) << 15;
    localparam logic [30:0]  IP_HALF = 31'(1) << 15;

    logic [WPW-1:0]        w_prod;
    logic [WPW:0]          w_rnd;
    logic [DATA_WIDTH-1:0] s4_a_reg;
    logic                  s4_neg_reg;
    logic                  s4_sat_reg;
    logic [VW-1:0]         s4_w_reg;

    logic [WW-1:0]         p_wide;
    logic [PW-1:0]         p;
    logic [5:0]            idx;
    logic [16:0]           lo;
    logic [16:0]           hi;
    logic [DATA_WIDTH-1:0] s5_a_reg;
    logic                  s5_neg_reg;
    logic                  s5_sat_reg;
    logic [16:0]           s5_lo_reg;
    logic [13:0]           s5_delta_reg;
    logic [15:0]           s5_frac_reg;

    logic [29:0]           ip_prod;
    logic [30:0]           ip_rnd;
    logic [DATA_WIDTH-1:0] s6_a_reg;
    logic                  s6_neg_reg;
    logic [16:0]           s6_t_reg;

    // w = 0.7978846 * v
    assign w_prod = WPW'(gta_pkg::GK_SCALE) * WPW'(v_in);
    assign w_rnd  = {1'b0, w_prod} + W_HALF;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s4_a_reg   <= a_in;
            s4_neg_reg <= neg_in;
            s4_sat_reg <= sat_in;
            s4_w_reg   <= w_rnd[16 +: VW];
        end
    end

    // table position in steps of 1/8 with a 16-bit fraction
    assign p_wide = (WW'(s4_w_reg) << SHL) >> SHR;
    assign p      = p_wide[PW-1:0];
    assign idx    = p[21:16];
    assign lo     = gta_pkg::tanh_entry(idx);
    assign hi     = gta_pkg::tanh_entry(idx + 6'd1);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s5_a_reg     <= s4_a_reg;
            s5_neg_reg   <= s4_neg_reg;
            s5_sat_reg   <= s4_sat_reg || (idx >= gta_pkg::TAB_STEPS);
            s5_lo_reg    <= lo;
            s5_delta_reg <= 14'(hi - lo);
            s5_frac_reg  <= p[15:0];
        end
    end

    assign ip_prod = s5_delta_reg * s5_frac_reg;
    assign ip_rnd  = {1'b0, ip_prod} + IP_HALF;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s6_a_reg   <= s5_a_reg;
            s6_neg_reg <= s5_neg_reg;
            s6_t_reg   <= s5_sat_reg ? gta_pkg::T_ONE : (s5_lo_reg + 17'(ip_rnd[30:16]));
        end
    end

    assign a_out   = s6_a_reg;
    assign neg_out = s6_neg_reg;
    assign t_out   = s6_t_reg;

endmodule

`default_nettype wire

@@ sv/gta_scale.sv @@
// back stages: x * (1 +/- tanh) / 2, rounding, sign and clamp
`default_nettype none

module gta_scale #(
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic [1:0]            en,
    input  wire logic [DATA_WIDTH-1:0] a_in,
    input  wire logic                  neg_in,
    input  wire logic [16:0]           t_in,
    output logic [DATA_WIDTH-1:0]      gelu_value
);

    localparam int PRW = DATA_WIDTH + 18;

    localparam logic [PRW:0] P_HALF = (PRW+1)'(1) << 16;
    localparam logic signed [DATA_WIDTH+1:0] YMAX = {3'b000, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH+1:0] YMIN = {3'b111, {(DATA_WIDTH-1){1'b0}}};

    logic [17:0]                    m;
    logic [PRW-1:0]                 s7_prod_reg;
    logic                           s7_neg_reg;

    logic [PRW:0]                   rnd;
    logic [DATA_WIDTH:0]            mag;
    logic signed [DATA_WIDTH+1:0]   ys;
    logic signed [DATA_WIDTH+1:0]   yc;
    logic [DATA_WIDTH-1:0]          s8_y_reg;

    // negative side uses 1 - tanh(|u|), positive side 1 + tanh(|u|)
    assign m = neg_in ? (18'(gta_pkg::T_ONE) - 18'(t_in)) : (18'(gta_pkg::T_ONE) + 18'(t_in));

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s7_prod_reg <= PRW'(a_in) * PRW'(m);
            s7_neg_reg  <= neg_in;
        end
    end

    // halving with round half away from zero on the magnitude
    assign rnd = {1'b0, s7_prod_reg} + P_HALF;
    assign mag = rnd[17 +: DATA_WIDTH+1];
    assign ys  = s7_neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    always_comb
    begin
        if (ys > YMAX)
        begin
            yc = YMAX;
        end
        else if (ys < YMIN)
        begin
            yc = YMIN;
        end
        else
        begin
            yc = ys;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s8_y_reg <= yc[DATA_WIDTH-1:0];
        end
    end

    assign gelu_value = s8_y_reg;

endmodule

`default_nettype wire

@@ sv/gelu_tanh_approx.sv @@
// gelu activation, tanh approximation, in signed fixed point
//
// s_* carries one signed sample per request (q5.10 by default) and m_* returns
// gelu(x) = 0.5*x*(1+tanh(0.7978846*(x+0.044715*x^3))) in the same format,
// rounded to nearest and clamped. tanh comes from a 32-entry table over [0,4]
// with linear interpolation and is 1.0 above that.
// the datapath is a nine-stage pipeline: magnitude, square, cube, polynomial,
// scale, table lookup, interpolation, product, round/clamp; an accepted request
// moves through these stage registers in order to m_tvalid/m_tdata.
// throughput is one request per cycle unless m_tready stalls the pipe, set by
// the single pass through each stage; no multiplier is shared between stages.
// each stage carries a valid bit; a stage takes new data when it is empty or
// the stage after it moves, so bubbles close up and s_tready stays high while
// any stage is free, even with a result waiting on m_tready.
// reset clears all valid bits; the datapath itself is not reset.
// when the receiver holds m_tready low the output stays stable and the pipe
// fills up, after which s_tready drops until the output is taken.
`default_nettype none

module gelu_tanh_approx #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 10
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     s_tdata,   // x_value
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]          m_tdata    // gelu_value
);

    localparam int TW = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int NS = 9;

    logic [NS-1:0]          vld_reg;
    logic [NS-1:0]          vld_next;
    logic [NS-1:0]          vld_in;
    logic [NS-1:0]          en;

    logic [DATA_WIDTH-1:0]  cb_a;
    logic                   cb_neg;
    logic                   cb_sat;
    logic [FRAC_BITS+2:0]   cb_v;
    logic [DATA_WIDTH-1:0]  th_a;
    logic                   th_neg;
    logic [16:0]            th_t;
    logic [DATA_WIDTH-1:0]  gelu_value;

    // a stage moves when it is empty or its successor moves
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign vld_in = {vld_reg[NS-2:0], s_tvalid};

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            vld_next[k] = en[k] ? vld_in[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    gta_cube #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_cube (
        .clk     (clk),
        .en      (en[3:0]),
        .x_value (s_tdata[DATA_WIDTH-1:0]),
        .a_out   (cb_a),
        .neg_out (cb_neg),
        .sat_out (cb_sat),
        .v_out   (cb_v)
    );

    gta_tanh #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_tanh (
        .clk     (clk),
        .en      (en[6:4]),
        .a_in    (cb_a),
        .neg_in  (cb_neg),
        .sat_in  (cb_sat),
        .v_in    (cb_v),
        .a_out   (th_a),
        .neg_out (th_neg),
        .t_out   (th_t)
    );

    gta_scale #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_scale (
        .clk        (clk),
        .en         (en[8:7]),
        .a_in       (th_a),
        .neg_in     (th_neg),
        .t_in       (th_t),
        .gelu_value (gelu_value)
    );

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = TW'(gelu_value);

endmodule

`default_nettype wire

@@ sv/gta_checker.sv @@
// port-level checks for the gelu pipeline and their bind to the top level
`default_nettype none

`include "assert_macros.svh"

module gta_checker #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 10
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata
);

    // gelu never goes below about -0.17; a quarter leaves room for rounding
    localparam longint GMIN = -(longint'(1) <<< (FRAC_BITS - 2));

    logic   s_fire;
    longint y_val;

    assign s_fire = s_tvalid && s_tready;
    assign y_val  = longint'($signed(m_tdata[DATA_WIDTH-1:0]));

    // a held result does not change
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a draining output frees every stage, so the input side must be open
    `ASSERT_IMPLY(a_ready_flow, clk, rst_n, m_tready || !m_tvalid, s_tready)

    // nothing comes out right after reset
    `ASSERT_IMPLY(a_reset_empty, clk, rst_n, !$past(rst_n), !m_tvalid)

    // sign handling: results stay at or above a floor of -0.25, below the gelu minimum
    `ASSERT_IMPLY(a_out_floor, clk, rst_n, m_tvalid, y_val >= GMIN)

    // an accepted sample of zero sees s_tready high in the same cycle
    `ASSERT_IMPLY(a_in_seen, clk, rst_n, s_fire && (s_tdata == '0), s_tready)

endmodule

bind gelu_tanh_approx gta_checker #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
) u_gta_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
